[design/fnms_pkg.sv]
// Shared constants, codes and types of the fuzzy name match scorer.
package fnms_pkg;

  localparam int unsigned QueryMax     = 24;
  localparam int unsigned TagBits      = 16;
  localparam int unsigned CfgIndexBits = 2;
  localparam int unsigned CfgDataBits  = 64;

  localparam logic [3:0] SatMax      = 4'd15;
  localparam logic [3:0] DistLimit   = 4'd3;
  localparam logic [3:0] DistBase    = 4'd10;
  localparam logic [3:0] ScoreExact  = 4'd0;
  localparam logic [3:0] ScorePrefix = 4'd1;
  localparam logic [3:0] ScoreSubstr = 4'd2;
  localparam logic [3:0] ScoreNone   = 4'd0;

  typedef enum logic [1:0] {
    CfgQueryLength,
    CfgBytesLow,
    CfgBytesMid,
    CfgBytesHigh
  } cfg_index_e;

  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StHold
  } state_e;

  // Handoff from one distance cell to its right neighbor.
  typedef struct packed {
    logic       fire;
    logic [3:0] row;
    logic [3:0] old;
  } link_t;

endpackage

[design/fuzzy_name_match_scorer.sv]
// Top level of the fuzzy name match scorer: query registers, match flags, cell row and result register.
//
// Symbol names arrive one byte per item and are scored against the query held in
// the configuration registers. Each accepted byte starts a wavefront that crosses
// the row of QUERY_MAX+1 distance cells one cell per cycle, so the next byte is
// accepted only once the wavefront has left the last cell. The last byte of a name
// puts one result into the output register; if that register is still occupied,
// the block waits until it is taken before accepting the next byte. The output
// tdata holds result_tag, kept and score from the lowest bit up.
module fuzzy_name_match_scorer #(
  parameter int unsigned QUERY_MAX = fnms_pkg::QueryMax,
  parameter int unsigned TAG_BITS  = fnms_pkg::TagBits
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [fnms_pkg::CfgIndexBits-1:0]       cfg_index_i,
  input  logic [fnms_pkg::CfgDataBits-1:0]        cfg_data_i,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // Fields from the lowest bit up: name_byte, tag.
  input  logic [((8+TAG_BITS+7)/8)*8-1:0]         s_axis_tdata,
  input  logic                                    s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // Fields from the lowest bit up: result_tag, kept, score.
  output logic [((TAG_BITS+5+7)/8)*8-1:0]         m_axis_tdata
);
  import fnms_pkg::*;

  localparam int unsigned OutBits = ((TAG_BITS + 5 + 7) / 8) * 8;
  localparam int unsigned IW      = $clog2(QUERY_MAX + 1);
  localparam int unsigned PW      = $clog2(QUERY_MAX + 2);
  localparam logic [PW-1:0] PosMax = PW'(QUERY_MAX + 1);

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
  endfunction

  state_e state_q, state_d;

  logic [4:0]          qlen_cfg_q;
  logic [63:0]         qlow_q, qmid_q, qhigh_q;
  logic [191:0]        qall;
  logic [7:0]          qb [QUERY_MAX];
  logic [4:0]          qlen;

  logic [7:0]          char_q;
  logic                last_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                start_q;
  logic [PW-1:0]       position_q, position_d;
  logic [QUERY_MAX-1:0] sv_q, sv_d, eq;
  logic                seen_q, seen_d, hit;
  logic                prefix_q, prefix_d;
  logic                exact_q, exact_d;
  logic [7:0]          p_byte;
  logic                pos_lt_len;

  logic                m_tvalid_q;
  logic [TAG_BITS-1:0] rtag_q;
  logic                kept_q, kept_d;
  logic [3:0]          score_q, score_d;

  logic                accept, emit, out_free, sweep_done;
  logic [7:0]          in_byte;
  logic [TAG_BITS-1:0] in_tag;
  logic [3:0]          edit_dist;

  link_t               links [QUERY_MAX+2];
  logic [3:0]          row [QUERY_MAX+1];
  logic [QUERY_MAX+1:0] fire_vec;

  assign cfg_ready_o = 1'b1;
  assign qall        = {qhigh_q, qmid_q, qlow_q};
  assign qlen        = (qlen_cfg_q > 5'(QUERY_MAX)) ? 5'(QUERY_MAX) : qlen_cfg_q;
  assign in_byte     = s_axis_tdata[7:0];
  assign in_tag      = s_axis_tdata[8 +: TAG_BITS];
  assign accept      = s_axis_tvalid & s_axis_tready;
  assign out_free    = !m_tvalid_q || m_axis_tready;
  assign sweep_done  = links[QUERY_MAX+1].fire;

  always_comb begin
    for (int j = 0; j < QUERY_MAX; j++) begin
      qb[j] = qall[j*8 +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_cfg_q <= '0;
      qlow_q     <= '0;
      qmid_q     <= '0;
      qhigh_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CfgQueryLength: qlen_cfg_q <= cfg_data_i[4:0];
        CfgBytesLow:    qlow_q     <= cfg_data_i;
        CfgBytesMid:    qmid_q     <= cfg_data_i;
        CfgBytesHigh:   qhigh_q    <= cfg_data_i;
        default:        qlen_cfg_q <= qlen_cfg_q;
      endcase
    end
  end

  always_comb begin
    p_byte = 8'h00;
    for (int j = 0; j < QUERY_MAX; j++) begin
      if (PW'(j) == position_q) begin
        p_byte = qb[j];
      end
    end
    pos_lt_len = 6'(position_q) < 6'(qlen);
    exact_d    = exact_q & pos_lt_len & (p_byte == in_byte);
    prefix_d   = prefix_q & (!pos_lt_len | (to_lower(p_byte) == to_lower(in_byte)));
    for (int j = 0; j < QUERY_MAX; j++) begin
      eq[j] = (qb[j] == in_byte);
    end
    sv_d = ((sv_q << 1) | QUERY_MAX'(1)) & eq;
    hit  = 1'b0;
    for (int j = 0; j < QUERY_MAX; j++) begin
      if (5'(j + 1) == qlen) begin
        hit = sv_d[j];
      end
    end
    seen_d     = seen_q | hit;
    position_d = (position_q < PosMax) ? PW'(position_q + 1'b1) : PosMax;
  end

  assign links[0] = '{fire: start_q, row: SatMax, old: SatMax};

  for (genvar j = 0; j <= QUERY_MAX; j++) begin : g_cell
    localparam logic [3:0] Init = (j > 15) ? SatMax : 4'(j);
    logic [7:0] cell_qbyte;
    if (j == 0) begin : g_first
      assign cell_qbyte = 8'h00;
    end else begin : g_rest
      assign cell_qbyte = qb[j-1];
    end
    fnms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .init_i  (Init),
      .char_i  (char_q),
      .qbyte_i (cell_qbyte),
      .clear_i (emit),
      .left_i  (links[j]),
      .right_o (links[j+1])
    );
    assign row[j] = links[j+1].row;
  end

  always_comb begin
    for (int j = 0; j <= QUERY_MAX + 1; j++) begin
      fire_vec[j] = links[j].fire;
    end
  end

  assign edit_dist = row[qlen[IW-1:0]];

  always_comb begin
    kept_d = 1'b1;
    if (exact_q && (6'(position_q) == 6'(qlen))) begin
      score_d = ScoreExact;
    end else if (prefix_q && (6'(position_q) >= 6'(qlen))) begin
      score_d = ScorePrefix;
    end else if (seen_q) begin
      score_d = ScoreSubstr;
    end else if ((edit_dist <= DistLimit) && (5'(edit_dist) < qlen)) begin
      score_d = DistBase + edit_dist;
    end else begin
      score_d = ScoreNone;
      kept_d  = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StSweep;
        end
      end
      StSweep: begin
        if (sweep_done) begin
          if (!last_q || out_free) begin
            state_d = StIdle;
          end else begin
            state_d = StHold;
          end
        end
      end
      StHold: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    case (state_q)
      StIdle:  s_axis_tready = 1'b1;
      StSweep: emit = sweep_done & last_q & out_free;
      StHold:  emit = out_free;
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      start_q    <= 1'b0;
      position_q <= '0;
      sv_q       <= '0;
      seen_q     <= 1'b0;
      prefix_q   <= 1'b1;
      exact_q    <= 1'b1;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept;
      if (accept) begin
        position_q <= position_d;
        sv_q       <= sv_d;
        seen_q     <= seen_d;
        prefix_q   <= prefix_d;
        exact_q    <= exact_d;
      end else if (emit) begin
        position_q <= '0;
        sv_q       <= '0;
        seen_q     <= 1'b0;
        prefix_q   <= 1'b1;
        exact_q    <= 1'b1;
      end
      if (emit) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= in_byte;
      last_q <= s_axis_tlast;
      tag_q  <= in_tag;
    end
    if (emit) begin
      rtag_q  <= tag_q;
      kept_q  <= kept_d;
      score_q <= score_d;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = OutBits'({score_q, kept_q, rtag_q});

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(fire_vec))
    else $error("More than one distance cell is updating at once.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (fire_vec == '0))
    else $error("A cell is updating while the block is idle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StHold) |-> m_tvalid_q)
    else $error("Waiting on the output register while it is empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |-> last_q)
    else $error("A result was produced for a byte that does not end a name.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && !kept_q) |-> (score_q == ScoreNone))
    else $error("A rejected symbol carries a nonzero score.");

endmodule

[design/fnms_cell.sv]
// One cell of the edit-distance row: holds one saturating entry and updates it on the wavefront.
module fnms_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [3:0]     init_i,
  input  logic [7:0]     char_i,
  input  logic [7:0]     qbyte_i,
  input  logic           clear_i,
  input  fnms_pkg::link_t left_i,
  output fnms_pkg::link_t right_o
);
  import fnms_pkg::*;

  logic       fresh_q;
  logic       fire_q;
  logic [3:0] row_q;
  logic [3:0] old_q;
  logic [3:0] row_cur;
  logic [4:0] up_sum;
  logic [4:0] left_sum;
  logic [4:0] diag_sum;
  logic [4:0] min_ab;
  logic [4:0] min_all;
  logic [3:0] row_d;

  assign row_cur  = fresh_q ? init_i : row_q;
  assign up_sum   = {1'b0, row_cur} + 5'd1;
  assign left_sum = {1'b0, left_i.row} + 5'd1;
  assign diag_sum = {1'b0, left_i.old} + 5'(qbyte_i != char_i);

  always_comb begin
    min_ab  = (up_sum < left_sum) ? up_sum : left_sum;
    min_all = (diag_sum < min_ab) ? diag_sum : min_ab;
    row_d   = (min_all > {1'b0, SatMax}) ? SatMax : min_all[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      fire_q  <= 1'b0;
    end else begin
      fire_q <= left_i.fire;
      if (clear_i) begin
        fresh_q <= 1'b1;
      end else if (left_i.fire) begin
        fresh_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (left_i.fire) begin
      row_q <= row_d;
      old_q <= row_cur;
    end
  end

  assign right_o = '{fire: fire_q, row: row_cur, old: old_q};

endmodule
